// File: hdl/poram_pkg.sv
// ----------------------------------------------------------------------------
// poram_pkg
// shared constants, types and helpers for the path oram access controller
// ----------------------------------------------------------------------------
package poram_pkg;

  localparam int LEVELS      = 6;
  localparam int NUM_BLOCKS  = 32;
  localparam int STASH_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;

  localparam int LEAF_BITS  = LEVELS - 1;
  localparam int NODE_COUNT = (1 << LEVELS) - 1;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int ID_BITS    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int STASH_BITS = $clog2(STASH_DEPTH);
  localparam int FILL_BITS  = $clog2(STASH_DEPTH + 1);
  localparam int DEPTH_BITS = $clog2(LEVELS + 1);

  localparam int IN_ID_W    = 5;
  localparam int IN_LEAF_W  = 5;
  localparam int IO_DATA_W  = 32;
  localparam int OUT_FILL_W = 5;

  typedef enum logic [0:0] {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_t;

  typedef struct packed {
    logic                  valid;
    logic [ID_BITS-1:0]    id;
    logic [DATA_WIDTH-1:0] data;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RD,
    ST_MAP_WR,
    ST_PATH_RD,
    ST_PATH_WAIT,
    ST_PATH_PUT,
    ST_TARGET,
    ST_INSERT,
    ST_EV_NODE,
    ST_EV_SCAN,
    ST_EV_WAIT,
    ST_EV_CHECK,
    ST_FILL,
    ST_DONE
  } state_t;

  // node index of the path to leaf at the given depth
  function automatic logic [NODE_BITS-1:0] node_at(input logic [LEAF_BITS-1:0] leaf,
                                                   input logic [DEPTH_BITS-1:0] depth);
    logic [NODE_BITS-1:0] base;
    logic [LEAF_BITS-1:0] off;
    base = NODE_BITS'((1 << depth) - 1);
    off  = leaf >> (LEAF_BITS - int'(depth));
    return base + NODE_BITS'(off);
  endfunction

endpackage

// File: hdl/poram_if.sv
// ----------------------------------------------------------------------------
// poram_req_if / poram_rsp_if
// valid-ready channels for requests and responses
// ----------------------------------------------------------------------------
interface poram_req_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic [poram_pkg::IN_ID_W-1:0]      block_id;
  logic signed [poram_pkg::IO_DATA_W-1:0] write_value;
  logic [poram_pkg::IN_LEAF_W-1:0]    new_leaf;
  modport source (output valid, func, block_id, write_value, new_leaf, input ready);
  modport sink (input valid, func, block_id, write_value, new_leaf, output ready);
endinterface

interface poram_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [poram_pkg::IO_DATA_W-1:0] read_value;
  logic                                   stash_overflow;
  logic [poram_pkg::OUT_FILL_W-1:0]       stash_fill;
  modport source (output valid, read_value, stash_overflow, stash_fill, input ready);
  modport sink (input valid, read_value, stash_overflow, stash_fill, output ready);
endinterface

// File: hdl/poram_tree_mem.sv
// ----------------------------------------------------------------------------
// poram_tree_mem
// tree node storage with a valid bit per node and registered read
// ----------------------------------------------------------------------------
module poram_tree_mem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [poram_pkg::NODE_BITS-1:0] rd_addr,
  output poram_pkg::slot_t               rd_slot,
  input  logic                           wr_en,
  input  logic [poram_pkg::NODE_BITS-1:0] wr_addr,
  input  poram_pkg::slot_t               wr_slot
);
  import poram_pkg::*;

  logic [ID_BITS+DATA_WIDTH-1:0] mem [NODE_COUNT];
  logic [NODE_COUNT-1:0]         valid;
  logic [ID_BITS+DATA_WIDTH-1:0] rd_word;
  logic                          rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_slot.id, wr_slot.data};
    end
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= wr_slot.valid;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_slot = {rd_valid, rd_word};
endmodule

// File: hdl/poram_stash.sv
// ----------------------------------------------------------------------------
// poram_stash
// stash slots with valid bits; one slot read and one written per cycle,
// plus free-slot search and fill count over the valid bits
// ----------------------------------------------------------------------------
module poram_stash (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [poram_pkg::STASH_BITS-1:0] rd_addr,
  output poram_pkg::slot_t                 rd_slot,
  input  logic                             wr_en,
  input  logic [poram_pkg::STASH_BITS-1:0] wr_addr,
  input  poram_pkg::slot_t                 wr_slot,
  output logic                             has_free,
  output logic [poram_pkg::STASH_BITS-1:0] free_idx,
  output logic [poram_pkg::FILL_BITS-1:0]  fill
);
  import poram_pkg::*;

  logic [ID_BITS-1:0]    ids   [STASH_DEPTH];
  logic [DATA_WIDTH-1:0] datas [STASH_DEPTH];
  logic [STASH_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids[wr_addr]   <= wr_slot.id;
      datas[wr_addr] <= wr_slot.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= wr_slot.valid;
    end
  end

  assign rd_slot = {valid[rd_addr], ids[rd_addr], datas[rd_addr]};

  // priority search for the lowest free slot
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = STASH_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        has_free = 1'b1;
        free_idx = STASH_BITS'(i);
      end
    end
  end

  always_comb begin
    fill = '0;
    for (int i = 0; i < STASH_DEPTH; i++) begin
      fill = fill + FILL_BITS'(valid[i]);
    end
  end
endmodule

// File: hdl/path_oram_access.sv
// path_oram_access: path oram controller, one block per tree node
// throughput: one access at a time; not ready until the result is transferred
// reset: position map entries cleared by a sweep over all NUM_BLOCKS entries
//   after reset, tree and stash valid bits cleared at once
// ----------------------------------------------------------------------------
// path_oram_access
// sequencer over the tree memory, stash and position map
// ----------------------------------------------------------------------------
module path_oram_access (
  input logic        clk,
  input logic        rst,
  poram_req_if.sink  req,
  poram_rsp_if.source rsp
);
  import poram_pkg::*;

  state_t state, state_next;

  logic [LEAF_BITS-1:0] pmap [NUM_BLOCKS];
  logic [LEAF_BITS-1:0] pmap_rd;
  logic                 pmap_we;
  logic [ID_BITS-1:0]   pmap_waddr, pmap_raddr;
  logic [LEAF_BITS-1:0] pmap_wdata;
  logic [ID_BITS:0]     clr_cnt;
  logic                 clearing;

  logic                  func;
  logic [ID_BITS-1:0]    blk;
  logic [DATA_WIDTH-1:0] wdata;
  logic [LEAF_BITS-1:0]  fresh, old;
  logic [DEPTH_BITS-1:0] depth;
  logic [STASH_BITS:0]   scan;
  logic                  overflow;
  logic [DATA_WIDTH-1:0] rv;
  logic [FILL_BITS-1:0]  fill_r;
  slot_t                 cand;

  logic [NODE_BITS-1:0]  tr_raddr, tr_waddr;
  slot_t                 tr_rd, tr_wslot;
  logic                  tr_we;
  logic [STASH_BITS-1:0] st_raddr, st_waddr;
  slot_t                 st_rd, st_wslot;
  logic                  st_we, st_has_free;
  logic [STASH_BITS-1:0] st_free;
  logic [FILL_BITS-1:0]  st_fill;

  logic [NODE_BITS-1:0]  cur_node;
  logic [LEAF_BITS-1:0]  sh;

  poram_tree_mem u_tree (
    .clk, .rst, .rd_addr(tr_raddr), .rd_slot(tr_rd),
    .wr_en(tr_we), .wr_addr(tr_waddr), .wr_slot(tr_wslot)
  );

  poram_stash u_stash (
    .clk, .rst, .rd_addr(st_raddr), .rd_slot(st_rd),
    .wr_en(st_we), .wr_addr(st_waddr), .wr_slot(st_wslot),
    .has_free(st_has_free), .free_idx(st_free), .fill(st_fill)
  );

  assign clearing = !clr_cnt[ID_BITS];
  assign cur_node = node_at(old, depth);
  assign sh       = LEAF_BITS'(LEAF_BITS - int'(depth));

  // position map memory, registered read
  always_ff @(posedge clk) begin
    if (pmap_we) begin
      pmap[pmap_waddr] <= pmap_wdata;
    end
    pmap_rd <= pmap[pmap_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rsp.valid  = 1'b0;
    pmap_we    = 1'b0;
    pmap_waddr = blk;
    pmap_wdata = fresh;
    pmap_raddr = blk;
    tr_raddr   = cur_node;
    tr_we      = 1'b0;
    tr_waddr   = cur_node;
    tr_wslot   = '0;
    st_raddr   = scan[STASH_BITS-1:0];
    st_we      = 1'b0;
    st_waddr   = st_free;
    st_wslot   = '0;
    if (clearing) begin
      pmap_we    = 1'b1;
      pmap_waddr = clr_cnt[ID_BITS-1:0];
      pmap_wdata = '0;
    end
    case (state)
      ST_IDLE: begin
        req.ready = !clearing;
        if (req.valid && !clearing) state_next = ST_MAP_RD;
      end
      ST_MAP_RD: state_next = ST_MAP_WR;
      ST_MAP_WR: begin
        pmap_we    = 1'b1;
        state_next = ST_PATH_RD;
      end
      ST_PATH_RD: state_next = ST_PATH_WAIT;
      ST_PATH_WAIT: state_next = ST_PATH_PUT;
      ST_PATH_PUT: begin
        if (tr_rd.valid) begin
          tr_we    = 1'b1;
          tr_wslot = '0;
          st_we    = st_has_free;
          st_wslot = tr_rd;
        end
        state_next = (depth == '0) ? ST_TARGET : ST_PATH_RD;
      end
      ST_TARGET: begin
        if (st_rd.valid && st_rd.id == blk) begin
          if (func == FUNC_WRITE) begin
            st_we    = 1'b1;
            st_waddr = scan[STASH_BITS-1:0];
            st_wslot = {1'b1, blk, wdata};
          end
          state_next = ST_EV_NODE;
        end else if (scan == (STASH_BITS+1)'(STASH_DEPTH - 1)) begin
          state_next = (func == FUNC_WRITE) ? ST_INSERT : ST_EV_NODE;
        end
      end
      ST_INSERT: begin
        st_we      = st_has_free;
        st_wslot   = {1'b1, blk, wdata};
        state_next = ST_EV_NODE;
      end
      ST_EV_NODE: state_next = ST_EV_SCAN;
      ST_EV_SCAN: begin
        // tree read of the node is now valid
        if (tr_rd.valid || scan == (STASH_BITS+1)'(STASH_DEPTH)) begin
          state_next = (depth == '0) ? ST_FILL : ST_EV_NODE;
        end else if (!st_rd.valid) begin
          state_next = ST_EV_SCAN;
        end else begin
          pmap_raddr = st_rd.id;
          state_next = ST_EV_WAIT;
        end
      end
      ST_EV_WAIT: begin
        // keep the candidate's id on the map read port
        pmap_raddr = cand.id;
        state_next = ST_EV_CHECK;
      end
      ST_EV_CHECK: begin
        if ((pmap_rd >> sh) == (old >> sh)) begin
          tr_we      = 1'b1;
          tr_wslot   = cand;
          st_we      = 1'b1;
          st_waddr   = scan[STASH_BITS-1:0];
          st_wslot   = '0;
          state_next = (depth == '0) ? ST_FILL : ST_EV_NODE;
        end else if (scan == (STASH_BITS+1)'(STASH_DEPTH - 1)) begin
          state_next = (depth == '0) ? ST_FILL : ST_EV_NODE;
        end else begin
          state_next = ST_EV_SCAN;
        end
      end
      ST_FILL: state_next = ST_DONE;
      ST_DONE: begin
        rsp.valid = 1'b1;
        if (rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        func     <= req.func;
        blk      <= ID_BITS'(req.block_id % NUM_BLOCKS);
        wdata    <= DATA_WIDTH'(req.write_value);
        fresh    <= LEAF_BITS'(req.new_leaf);
        overflow <= 1'b0;
        rv       <= '0;
      end
      ST_MAP_RD: ;
      ST_MAP_WR: begin
        old   <= pmap_rd;
        depth <= DEPTH_BITS'(LEAF_BITS);
      end
      ST_PATH_PUT: begin
        if (tr_rd.valid && !st_has_free) overflow <= 1'b1;
        if (depth == '0) begin
          scan <= '0;
        end else begin
          depth <= depth - 1'b1;
        end
      end
      ST_TARGET: begin
        if (st_rd.valid && st_rd.id == blk) begin
          if (func == FUNC_READ) rv <= st_rd.data;
        end
        scan <= scan + 1'b1;
        if ((st_rd.valid && st_rd.id == blk) ||
            scan == (STASH_BITS+1)'(STASH_DEPTH - 1)) begin
          depth <= DEPTH_BITS'(LEAF_BITS);
        end
      end
      ST_INSERT: begin
        if (!st_has_free) overflow <= 1'b1;
      end
      ST_EV_NODE: scan <= '0;
      ST_EV_SCAN: begin
        if (tr_rd.valid || scan == (STASH_BITS+1)'(STASH_DEPTH)) begin
          depth <= depth - 1'b1;
        end else if (!st_rd.valid) begin
          scan <= scan + 1'b1;
        end else begin
          cand <= st_rd;
        end
      end
      ST_EV_CHECK: begin
        if ((pmap_rd >> sh) == (old >> sh) ||
            scan == (STASH_BITS+1)'(STASH_DEPTH - 1)) begin
          depth <= depth - 1'b1;
        end else begin
          scan <= scan + 1'b1;
        end
      end
      ST_FILL: fill_r <= st_fill;
      default: ;
    endcase
  end

  assign rsp.read_value     = IO_DATA_W'(signed'(rv));
  assign rsp.stash_overflow = overflow;
  assign rsp.stash_fill     = OUT_FILL_W'(fill_r);
endmodule

// File: test/poram_checker.sv
// ----------------------------------------------------------------------------
// poram_checker
// watches the request and response channels, keeps a shadow path oram and
// compares every response with the value predicted from accepted requests
// ----------------------------------------------------------------------------
module poram_checker (
  input  logic        clk,
  input  logic        rst,
  poram_req_if.sink   req,
  poram_rsp_if.sink   rsp,
  output int          fail_count,
  output int          pending,
  output int          rsp_count,
  output int          overflow_count
);
  import poram_pkg::*;

  typedef struct packed {
    logic signed [IO_DATA_W-1:0] read_value;
    logic                        stash_overflow;
    logic [OUT_FILL_W-1:0]       stash_fill;
  } access_rsp_t;

  logic [LEAF_BITS-1:0]  leaf_of [NUM_BLOCKS];
  logic                  node_valid [NODE_COUNT];
  logic [ID_BITS-1:0]    node_id [NODE_COUNT];
  logic [DATA_WIDTH-1:0] node_data [NODE_COUNT];
  logic                  st_valid [STASH_DEPTH];
  logic [ID_BITS-1:0]    st_id [STASH_DEPTH];
  logic [DATA_WIDTH-1:0] st_data [STASH_DEPTH];
  access_rsp_t           expected_rsp [$];

  function automatic int path_node(int leaf, int depth);
    return ((1 << depth) - 1) + (leaf >> (LEAF_BITS - depth));
  endfunction

  function automatic bit stash_insert(logic [ID_BITS-1:0] id, logic [DATA_WIDTH-1:0] data);
    for (int s = 0; s < STASH_DEPTH; s++) begin
      if (!st_valid[s]) begin
        st_valid[s] = 1'b1;
        st_id[s] = id;
        st_data[s] = data;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic access_rsp_t predict_access(logic fn, logic [IN_ID_W-1:0] bid,
                                                 logic [IO_DATA_W-1:0] wv,
                                                 logic [IN_LEAF_W-1:0] nl);
    access_rsp_t r;
    int blk, old, n, sh, fill;
    bit found;
    r = '0;
    blk = bid % NUM_BLOCKS;
    old = leaf_of[blk];
    leaf_of[blk] = nl[LEAF_BITS-1:0];
    found = 0;
    fill = 0;
    for (int d = LEAF_BITS; d >= 0; d--) begin
      n = path_node(old, d);
      if (node_valid[n]) begin
        if (!stash_insert(node_id[n], node_data[n])) r.stash_overflow = 1'b1;
        node_valid[n] = 1'b0;
      end
    end
    for (int s = 0; s < STASH_DEPTH; s++) begin
      if (st_valid[s] && st_id[s] == blk) begin
        found = 1;
        if (fn == FUNC_READ) r.read_value = st_data[s];
        else st_data[s] = wv[DATA_WIDTH-1:0];
        break;
      end
    end
    if (!found && fn == FUNC_WRITE)
      if (!stash_insert(ID_BITS'(blk), wv[DATA_WIDTH-1:0])) r.stash_overflow = 1'b1;
    for (int d = LEAF_BITS; d >= 0; d--) begin
      n = path_node(old, d);
      sh = LEAF_BITS - d;
      if (node_valid[n]) continue;
      for (int s = 0; s < STASH_DEPTH; s++) begin
        if (st_valid[s] && (int'(leaf_of[st_id[s]]) >> sh) == (old >> sh)) begin
          node_valid[n] = 1'b1;
          node_id[n] = st_id[s];
          node_data[n] = st_data[s];
          st_valid[s] = 1'b0;
          break;
        end
      end
    end
    for (int s = 0; s < STASH_DEPTH; s++) if (st_valid[s]) fill++;
    r.stash_fill = OUT_FILL_W'(fill);
    return r;
  endfunction

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    access_rsp_t e;
    if (rst) begin
      for (int b = 0; b < NUM_BLOCKS; b++) leaf_of[b] = '0;
      for (int n = 0; n < NODE_COUNT; n++) node_valid[n] = 1'b0;
      for (int s = 0; s < STASH_DEPTH; s++) st_valid[s] = 1'b0;
      expected_rsp.delete();
      fail_count <= 0;
      rsp_count <= 0;
      overflow_count <= 0;
    end else begin
      if (req.valid && req.ready) begin
        e = predict_access(req.func, req.block_id, req.write_value, req.new_leaf);
        if (e.stash_overflow) overflow_count <= overflow_count + 1;
        expected_rsp = {expected_rsp, e};
      end
      if (rsp.valid && rsp.ready) begin
        rsp_count <= rsp_count + 1;
        if (expected_rsp.size() == 0) begin
          $display("%0t: response with nothing expected, got %h/%b/%0d", $time,
                   rsp.read_value, rsp.stash_overflow, rsp.stash_fill);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_rsp.pop_front();
          if (e.read_value !== rsp.read_value || e.stash_overflow !== rsp.stash_overflow ||
              e.stash_fill !== rsp.stash_fill) begin
            $display("%0t: mismatch expected %h/%b/%0d actual %h/%b/%0d", $time,
                     e.read_value, e.stash_overflow, e.stash_fill,
                     rsp.read_value, rsp.stash_overflow, rsp.stash_fill);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives random and directed path oram accesses with bursty traffic and a
// stalling receiver; the checker beside the block judges every response
// ----------------------------------------------------------------------------
module tb_top;
  import poram_pkg::*;

  localparam int RANDOM_ITEMS = 860;
  localparam int IDLE_LIMIT   = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, rsp_count, overflow_count;
  int   idle_cycles = 0;
  int   sent = 0;
  bit   long_hold = 0;

  poram_req_if req ();
  poram_rsp_if rsp ();

  path_oram_access i_dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  poram_checker i_checker (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.sink),
    .fail_count(fail_count), .pending(pending), .rsp_count(rsp_count),
    .overflow_count(overflow_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.func = FUNC_READ;
    req.block_id = '0;
    req.write_value = '0;
    req.new_leaf = '0;
    rsp.ready = 1'b0;
  end

  // offer one access and hold it until the transfer
  task automatic send_access(logic fn, logic [IN_ID_W-1:0] bid, logic [IO_DATA_W-1:0] wv,
                             logic [IN_LEAF_W-1:0] nl);
    req.valid <= 1'b1;
    req.func <= fn;
    req.block_id <= bid;
    req.write_value <= wv;
    req.new_leaf <= nl;
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  task automatic pause_sender(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // receiver: random stall pattern, one long hold-off on request
  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        rsp.ready <= 1'b0;
        hold = 3000;
        repeat (hold) @(posedge clk);
        long_hold = 0;
      end
      case ($urandom_range(0, 3))
        0: rsp.ready <= 1'b0;
        default: rsp.ready <= 1'b1;
      endcase
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, nothing transferred for %0d cycles", $time, idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic fn;
    logic [IN_ID_W-1:0] bid;
    int burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: unwritten read, extremes of every field, same block over and over
    send_access(FUNC_READ, 5'd0, 32'h0, 5'd0);
    send_access(FUNC_WRITE, 5'd0, 32'h7fffffff, 5'd31);
    send_access(FUNC_READ, 5'd0, 32'hffffffff, 5'd0);
    send_access(FUNC_WRITE, 5'd31, 32'h80000000, 5'd0);
    send_access(FUNC_READ, 5'd31, 32'h0, 5'd31);
    send_access(FUNC_WRITE, 5'd31, 32'hffffffff, 5'd16);
    send_access(FUNC_READ, 5'd31, 32'h5a5a5a5a, 5'd15);
    send_access(FUNC_READ, 5'd17, 32'h0, 5'd21);
    send_access(FUNC_WRITE, 5'd0, 32'h0, 5'd10);
    send_access(FUNC_READ, 5'd0, 32'h0, 5'd10);
    // blocks 1 to 14 written onto leaf 0 so that the stash fills
    for (int b = 1; b < 15; b++) send_access(FUNC_WRITE, 5'(b), $urandom, 5'd0);
    pause_sender(5);
    // random traffic; the pause at item 100 waits for the pipe to drain, one long hold-off
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) begin
        req.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (i == 300) long_hold = 1;
      if (i % 50 == 0 && $urandom_range(0, 1)) begin
        // bursts onto leaves 0 and 1 push the stash to its limit
        for (int k = 0; k < 18; k++)
          send_access(FUNC_WRITE, 5'($urandom), $urandom, 5'($urandom_range(0, 1)));
      end
      fn = 1'($urandom_range(0, 1));
      bid = (i % 3 == 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
      send_access(fn, bid, $urandom, 5'($urandom));
      burst = $urandom_range(0, 7);
      if (burst == 0) pause_sender($urandom_range(1, 300));
    end
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    $display("sent %0d accesses, %0d responses checked, %0d with stash overflow",
             sent, rsp_count, overflow_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
